### rtl/dpwp_pkg.sv
// Package for the depth pixel to world point block: widths, register indexes,
// reset values and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package dpwp_pkg;

    // Pixel coordinate width (valid range 8 to 16).
    localparam int COORD_BITS = 12;

    localparam int DEPTH_W    = 16;
    localparam int ROT_W      = 16;
    localparam int INV_W      = 32;
    localparam int FRAC_CAM   = 12;
    localparam int FRAC_ROT   = 14;
    localparam int FRAC_ACC   = FRAC_CAM + FRAC_ROT;

    // Magnitude of (u*16 - cx) and its signed difference.
    localparam int MAG_W      = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
    localparam int DIFF_W     = MAG_W + 1;
    // Offset times depth, then times the inverse focal length.
    localparam int PROD_W     = MAG_W + DEPTH_W;
    localparam int FULL_W     = PROD_W + INV_W;
    // Camera coordinates in Q.12 mm, signed.
    localparam int XC_W       = FULL_W - 23;
    localparam int ZC_W       = DEPTH_W + FRAC_CAM + 1;
    // Pose products and their sum.
    localparam int PX_W       = XC_W + ROT_W;
    localparam int PZ_W       = ZC_W + ROT_W;
    localparam int TR_W       = ROT_W + FRAC_ACC;
    localparam int ACC_W      = PX_W + 2;
    localparam int RND_W      = ACC_W + 1 - FRAC_ACC;

    // Register stages from the input edge to the result.
    localparam int LAT        = 7;

    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_WINDOW    = 3'd0,
        CFG_SWAP_BYTES      = 3'd1,
        CFG_PRINCIPAL_POINT = 3'd2,
        CFG_INVERSE_FOCAL   = 3'd3,
        CFG_POSE_ROW_X      = 3'd4,
        CFG_POSE_ROW_Y      = 3'd5,
        CFG_POSE_ROW_Z      = 3'd6
    } t_cfg_index;

    localparam logic [DEPTH_W-1:0] NO_RETURN = 16'hFFFF;

    localparam logic [31:0] RST_DEPTH_WINDOW    = {16'd3000, 16'd150};
    localparam logic [31:0] RST_PRINCIPAL_POINT = 32'd0;
    localparam logic [63:0] RST_INVERSE_FOCAL   = 64'd0;
    localparam logic [63:0] RST_POSE_ROW_X      = 64'h0000_0000_0000_4000;
    localparam logic [63:0] RST_POSE_ROW_Y      = 64'h0000_0000_4000_0000;
    localparam logic [63:0] RST_POSE_ROW_Z      = 64'h0000_4000_0000_0000;

    // Half an LSB for the camera rounding (24 bits dropped) and the world
    // rounding (26 bits dropped).
    localparam logic [FULL_W:0] BP_ROUND = {{(FULL_W - 23){1'b0}}, 1'b1, 23'd0};
    localparam logic [ACC_W:0]  WR_ROUND =
        {{(ACC_W - FRAC_ACC + 1){1'b0}}, 1'b1, {(FRAC_ACC - 1){1'b0}}};

    localparam logic [RND_W-1:0] SAT_POS_MAG = RND_W'(32767);
    localparam logic [RND_W-1:0] SAT_NEG_MAG = RND_W'(32768);
    localparam logic [15:0]      SAT_POS     = 16'h7FFF;
    localparam logic [15:0]      SAT_NEG     = 16'h8000;

endpackage

### rtl/dpwp_back_project.sv
// One camera axis of the back-projection: |offset| * depth * inverse focal,
// rounded half away from zero to Q.12 mm. Three register stages. Uses dpwp_pkg.
`timescale 1ns / 1ps

module dpwp_back_project (
    input  logic                             i_clk,
    input  logic                             i_neg,
    input  logic [dpwp_pkg::MAG_W-1:0]       i_mag,
    input  logic [dpwp_pkg::DEPTH_W-1:0]     i_depth,
    input  logic [dpwp_pkg::INV_W-1:0]       i_inv,
    output logic signed [dpwp_pkg::XC_W-1:0] o_coord
);
    import dpwp_pkg::*;

    logic              r_neg2;
    logic              r_neg3;
    logic [PROD_W-1:0] r_p;
    logic [FULL_W-1:0] r_prod;
    logic [FULL_W:0]   n_sum;
    logic [XC_W-1:0]   n_mag;
    logic [XC_W-1:0]   r_coord;

    // Stage 2: offset times depth. Stage 3: times the inverse focal length.
    always_ff @(posedge i_clk) begin
        r_neg2 <= i_neg;
        r_p    <= PROD_W'(i_mag) * PROD_W'(i_depth);
        r_neg3 <= r_neg2;
        r_prod <= FULL_W'(r_p) * FULL_W'(i_inv);
    end

    always_comb begin
        n_sum = {1'b0, r_prod} + BP_ROUND;
        n_mag = n_sum[FULL_W:24];
    end

    // Stage 4: round, then restore the sign of the offset.
    always_ff @(posedge i_clk) begin
        r_coord <= r_neg3 ? (XC_W'(0) - n_mag) : n_mag;
    end

    assign o_coord = $signed(r_coord);

endmodule

### rtl/dpwp_world_axis.sv
// One row of the pose transform: r0*xc + r1*yc + r2*zc + t, then rounding to
// integer mm and 16-bit saturation. Three register stages. Uses dpwp_pkg.
`timescale 1ns / 1ps

module dpwp_world_axis (
    input  logic                             i_clk,
    input  logic [63:0]                      i_row,
    input  logic signed [dpwp_pkg::XC_W-1:0] i_xc,
    input  logic signed [dpwp_pkg::XC_W-1:0] i_yc,
    input  logic signed [dpwp_pkg::ZC_W-1:0] i_zc,
    output logic signed [15:0]               o_coord
);
    import dpwp_pkg::*;

    logic signed [PX_W-1:0]  n_px;
    logic signed [PX_W-1:0]  n_py;
    logic signed [PZ_W-1:0]  n_pz;
    logic signed [PX_W-1:0]  r_px;
    logic signed [PX_W-1:0]  r_py;
    logic signed [PZ_W-1:0]  r_pz;
    logic [ACC_W-1:0]        n_acc;
    logic [ACC_W-1:0]        r_acc;
    logic [TR_W-1:0]         n_tr;
    logic                    n_neg;
    logic [ACC_W-1:0]        n_abs;
    logic [ACC_W:0]          n_rsum;
    logic [RND_W-1:0]        n_rnd;
    logic [15:0]             n_res;
    logic [15:0]             r_res;

    always_comb begin
        n_px = $signed(i_row[15:0])  * i_xc;
        n_py = $signed(i_row[31:16]) * i_yc;
        n_pz = $signed(i_row[47:32]) * i_zc;
    end

    // Stage 5: the three rotation products.
    always_ff @(posedge i_clk) begin
        r_px <= n_px;
        r_py <= n_py;
        r_pz <= n_pz;
    end

    always_comb begin
        n_tr  = {i_row[63:48], {FRAC_ACC{1'b0}}};
        n_acc = {{(ACC_W - PX_W){r_px[PX_W-1]}}, r_px}
              + {{(ACC_W - PX_W){r_py[PX_W-1]}}, r_py}
              + {{(ACC_W - PZ_W){r_pz[PZ_W-1]}}, r_pz}
              + {{(ACC_W - TR_W){n_tr[TR_W-1]}}, n_tr};
    end

    // Stage 6: sum with the translation at 26 fraction bits.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Round the magnitude half away from zero, then clamp to 16 bits.
    always_comb begin
        n_neg  = r_acc[ACC_W-1];
        n_abs  = n_neg ? (ACC_W'(0) - r_acc) : r_acc;
        n_rsum = {1'b0, n_abs} + WR_ROUND;
        n_rnd  = n_rsum[ACC_W:FRAC_ACC];
        if (n_neg) begin
            n_res = (n_rnd > SAT_NEG_MAG) ? SAT_NEG : (16'd0 - n_rnd[15:0]);
        end else begin
            n_res = (n_rnd > SAT_POS_MAG) ? SAT_POS : n_rnd[15:0];
        end
    end

    // Stage 7: result register.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_coord = $signed(r_res);

endmodule

### rtl/depth_pixel_to_world_point.sv
// Top level of the depth pixel to world point block: configuration registers,
// depth conditioning, valid pipeline. Uses dpwp_pkg, dpwp_back_project, dpwp_world_axis.
`timescale 1ns / 1ps

// A transaction is offered by raising start with a depth sample and its pixel
// column and row; it is taken at any clock edge where start is high and busy
// is low. busy is high only while reset is applied and during the cycle after,
// so in normal operation the block takes one transaction every clock. Each
// sample that passes the depth window yields one world point, shown for one
// cycle with o_strobe high; samples outside the window yield nothing and
// leave a gap in the output. Each point passes through the register
// stages of the datapath: depth conditioning and pixel offset, two
// multiplies per camera axis, rounding, the pose products, the pose sum,
// and final rounding with saturation. The receiver cannot stall the block and
// must take each point in the cycle it is strobed. Configuration registers are
// written through i_cfg_we, i_cfg_index and i_cfg_data and are expected to
// change only while no transaction is in flight.

module depth_pixel_to_world_point (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dpwp_pkg::DEPTH_W-1:0]      i_raw_depth,
    input  logic [dpwp_pkg::COORD_BITS-1:0]   i_pixel_column,
    input  logic [dpwp_pkg::COORD_BITS-1:0]   i_pixel_row,
    input  logic                              i_cfg_we,
    input  logic [dpwp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dpwp_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic signed [15:0]                o_world_x,
    output logic signed [15:0]                o_world_y,
    output logic signed [15:0]                o_world_z,
    output logic [dpwp_pkg::COORD_BITS-1:0]   o_point_column,
    output logic [dpwp_pkg::COORD_BITS-1:0]   o_point_row
);
    import dpwp_pkg::*;

    // Configuration registers.
    logic [31:0]            r_depth_window;
    logic                   r_swap;
    logic [31:0]            r_principal;
    logic [63:0]            r_inv_focal;
    logic [63:0]            r_pose_x;
    logic [63:0]            r_pose_y;
    logic [63:0]            r_pose_z;

    logic                   r_busy;
    logic [LAT-1:0]         r_vld;
    logic [COORD_BITS-1:0]  r_col [LAT];
    logic [COORD_BITS-1:0]  r_row [LAT];

    // Stage 1 results.
    logic [DEPTH_W-1:0]     n_swapped;
    logic [DEPTH_W-1:0]     n_depth;
    logic                   n_in_window;
    logic                   n_take;
    logic [DIFF_W-1:0]      n_diff_x;
    logic [DIFF_W-1:0]      n_diff_y;
    logic [MAG_W-1:0]       n_mag_x;
    logic [MAG_W-1:0]       n_mag_y;
    logic                   r_neg_x;
    logic                   r_neg_y;
    logic [MAG_W-1:0]       r_mag_x;
    logic [MAG_W-1:0]       r_mag_y;
    logic [DEPTH_W-1:0]     r_d1;
    logic [DEPTH_W-1:0]     r_d2;
    logic [DEPTH_W-1:0]     r_d3;
    logic [DEPTH_W-1:0]     r_d4;

    logic signed [XC_W-1:0] w_xc;
    logic signed [XC_W-1:0] w_yc;
    logic signed [ZC_W-1:0] w_zc;

    // Register writes. Indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_window <= RST_DEPTH_WINDOW;
            r_swap         <= 1'b0;
            r_principal    <= RST_PRINCIPAL_POINT;
            r_inv_focal    <= RST_INVERSE_FOCAL;
            r_pose_x       <= RST_POSE_ROW_X;
            r_pose_y       <= RST_POSE_ROW_Y;
            r_pose_z       <= RST_POSE_ROW_Z;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DEPTH_WINDOW:    r_depth_window <= i_cfg_data[31:0];
                CFG_SWAP_BYTES:      r_swap         <= i_cfg_data[0];
                CFG_PRINCIPAL_POINT: r_principal    <= i_cfg_data[31:0];
                CFG_INVERSE_FOCAL:   r_inv_focal    <= i_cfg_data;
                CFG_POSE_ROW_X:      r_pose_x       <= i_cfg_data;
                CFG_POSE_ROW_Y:      r_pose_y       <= i_cfg_data;
                CFG_POSE_ROW_Z:      r_pose_z       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // busy only covers reset; the datapath itself never pushes back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // Depth conditioning: optional byte swap, the no-return code reads as
    // zero, and the window test decides whether a point is produced at all.
    // The pixel offsets u*16 - cx and v*16 - cy are split into sign and
    // magnitude so the multipliers downstream stay unsigned.
    always_comb begin
        n_take      = start && !r_busy;
        n_swapped   = r_swap ? {i_raw_depth[7:0], i_raw_depth[15:8]} : i_raw_depth;
        n_depth     = (n_swapped == NO_RETURN) ? '0 : n_swapped;
        n_in_window = (n_depth >= r_depth_window[15:0]) &&
                      (n_depth <= r_depth_window[31:16]);
        n_diff_x    = {{(DIFF_W - COORD_BITS - 4){1'b0}}, i_pixel_column, 4'd0}
                    - {{(DIFF_W - 16){1'b0}}, r_principal[15:0]};
        n_diff_y    = {{(DIFF_W - COORD_BITS - 4){1'b0}}, i_pixel_row, 4'd0}
                    - {{(DIFF_W - 16){1'b0}}, r_principal[31:16]};
        n_mag_x     = n_diff_x[DIFF_W-1] ? MAG_W'(DIFF_W'(0) - n_diff_x)
                                         : n_diff_x[MAG_W-1:0];
        n_mag_y     = n_diff_y[DIFF_W-1] ? MAG_W'(DIFF_W'(0) - n_diff_y)
                                         : n_diff_y[MAG_W-1:0];
    end

    // Valid bits travel alongside the data; of the pipeline registers only they are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], n_take && n_in_window};
        end
    end

    // Stage 1 payload and the pixel echo shift line.
    always_ff @(posedge i_clk) begin
        r_neg_x  <= n_diff_x[DIFF_W-1];
        r_neg_y  <= n_diff_y[DIFF_W-1];
        r_mag_x  <= n_mag_x;
        r_mag_y  <= n_mag_y;
        r_d1     <= n_depth;
        r_d2     <= r_d1;
        r_d3     <= r_d2;
        r_d4     <= r_d3;
        r_col[0] <= i_pixel_column;
        r_row[0] <= i_pixel_row;
        for (int i = 1; i < LAT; i++) begin
            r_col[i] <= r_col[i-1];
            r_row[i] <= r_row[i-1];
        end
    end

    // Stages 2 to 4: camera x and y in Q.12 mm.
    dpwp_back_project u_bp_x (
        .i_clk   (i_clk),
        .i_neg   (r_neg_x),
        .i_mag   (r_mag_x),
        .i_depth (r_d1),
        .i_inv   (r_inv_focal[31:0]),
        .o_coord (w_xc)
    );

    dpwp_back_project u_bp_y (
        .i_clk   (i_clk),
        .i_neg   (r_neg_y),
        .i_mag   (r_mag_y),
        .i_depth (r_d1),
        .i_inv   (r_inv_focal[63:32]),
        .o_coord (w_yc)
    );

    // Camera z is the depth itself at 12 fraction bits, aligned to stage 4.
    assign w_zc = $signed({1'b0, r_d4, {FRAC_CAM{1'b0}}});

    // Stages 5 to 7: one pose row per world axis.
    dpwp_world_axis u_wa_x (
        .i_clk   (i_clk),
        .i_row   (r_pose_x),
        .i_xc    (w_xc),
        .i_yc    (w_yc),
        .i_zc    (w_zc),
        .o_coord (o_world_x)
    );

    dpwp_world_axis u_wa_y (
        .i_clk   (i_clk),
        .i_row   (r_pose_y),
        .i_xc    (w_xc),
        .i_yc    (w_yc),
        .i_zc    (w_zc),
        .o_coord (o_world_y)
    );

    dpwp_world_axis u_wa_z (
        .i_clk   (i_clk),
        .i_row   (r_pose_z),
        .i_xc    (w_xc),
        .i_yc    (w_yc),
        .i_zc    (w_zc),
        .o_coord (o_world_z)
    );

    assign o_strobe       = r_vld[LAT-1];
    assign o_point_column = r_col[LAT-1];
    assign o_point_row    = r_row[LAT-1];

endmodule

### rtl/dpwp_checker.sv
// Port-level checks for depth_pixel_to_world_point and the bind that attaches
// them. Uses dpwp_pkg.
`timescale 1ns / 1ps

module dpwp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [dpwp_pkg::COORD_BITS-1:0]   i_pixel_column,
    input  logic [dpwp_pkg::COORD_BITS-1:0]   i_pixel_row,
    input  logic                              i_strobe,
    input  logic [dpwp_pkg::COORD_BITS-1:0]   i_point_column,
    input  logic [dpwp_pkg::COORD_BITS-1:0]   i_point_row
);
    import dpwp_pkg::*;

    // Reset flushes every transaction in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_strobe)
        else $error("result strobed right after reset");

    // Once out of reset the block takes a transaction every cycle.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !i_busy)
        else $error("busy raised outside reset");

    // Every result comes from a transaction that the block accepted.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe |-> $past(i_start && !i_busy, LAT))
        else $error("result without a matching transaction");

    // The echoed pixel belongs to that transaction.
    a_pixel_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe |-> (i_point_column == $past(i_pixel_column, LAT)) &&
                     (i_point_row == $past(i_pixel_row, LAT)))
        else $error("result carries the wrong pixel");

endmodule

bind depth_pixel_to_world_point dpwp_checker u_dpwp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_pixel_column (i_pixel_column),
    .i_pixel_row    (i_pixel_row),
    .i_strobe       (o_strobe),
    .i_point_column (o_point_column),
    .i_point_row    (o_point_row)
);

### tb/tb_depth_pixel_to_world_point.sv
// Self-checking testbench for depth_pixel_to_world_point: directed and random depth
// samples under many register settings, checked against an in-bench projection model.
// Depends on dpwp_pkg and the depth_pixel_to_world_point RTL.
`timescale 1ns / 1ps

module tb_depth_pixel_to_world_point;
    import dpwp_pkg::*;

    localparam int CB            = COORD_BITS;
    localparam int HALF_PERIOD   = 6;
    // Index 7 has no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    // Out-of-window samples leave no trace in the result stream, so after the
    // last expected point we still give the pipeline its full depth to empty.
    localparam int SETTLE_CYCLES = LAT + 3;
    localparam int DRAIN_LIMIT   = 40 * LAT;

    typedef struct packed {
        logic [15:0]   world_x;
        logic [15:0]   world_y;
        logic [15:0]   world_z;
        logic [CB-1:0] column;
        logic [CB-1:0] row;
    } t_point;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [DEPTH_W-1:0]   i_raw_depth;
    logic [CB-1:0]        i_pixel_column;
    logic [CB-1:0]        i_pixel_row;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_strobe;
    logic signed [15:0]   o_world_x;
    logic signed [15:0]   o_world_y;
    logic signed [15:0]   o_world_z;
    logic [CB-1:0]        o_point_column;
    logic [CB-1:0]        o_point_row;

    // Our own copy of the register file, updated whenever the bench writes one.
    logic [31:0] window_shadow;
    logic        swap_shadow;
    logic [31:0] centre_shadow;
    logic [63:0] inv_focal_shadow;
    logic [63:0] pose_shadow [3];

    // Points the block still owes us, oldest first.
    t_point pending_points [$];
    int     error_count;

    depth_pixel_to_world_point u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_raw_depth    (i_raw_depth),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_world_x      (o_world_x),
        .o_world_y      (o_world_y),
        .o_world_z      (o_world_z),
        .o_point_column (o_point_column),
        .o_point_row    (o_point_row)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Camera coordinate in Q.12 mm. The pixel offset is exact in Q.4; its
    // magnitude times depth times the Q0.32 inverse focal length carries 36
    // fraction bits, and we round half away from zero down to 12.
    function automatic longint camera_offset_q12(input logic [CB-1:0] pix,
                                                 input logic [15:0] centre_q4,
                                                 input logic [31:0] inv_focal,
                                                 input logic [15:0] depth);
        longint      diff;
        logic [95:0] scaled;
        diff = {pix, 4'h0};
        diff = diff - longint'(centre_q4);
        scaled = 96'((diff < 0) ? -diff : diff) * 96'(depth) * 96'(inv_focal);
        scaled = (scaled + (96'd1 << 23)) >> 24;
        return (diff < 0) ? -longint'(scaled[62:0]) : longint'(scaled[62:0]);
    endfunction

    // One pose row applied to the camera point. The sum is exact with 26
    // fraction bits; it is rounded half away from zero and saturated to 16 bits.
    function automatic logic [15:0] world_axis_mm(input logic [63:0] pose_row,
                                                  input longint xc, input longint yc,
                                                  input longint zc);
        longint acc;
        longint mag;
        acc = longint'($signed(pose_row[15:0]))  * xc
            + longint'($signed(pose_row[31:16])) * yc
            + longint'($signed(pose_row[47:32])) * zc
            + (longint'($signed(pose_row[63:48])) <<< FRAC_ACC);
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + (longint'(1) <<< (FRAC_ACC - 1))) >>> FRAC_ACC;
        if (acc < 0) begin
            return (mag > 32768) ? SAT_NEG : 16'(-mag);
        end else begin
            return (mag > 32767) ? SAT_POS : 16'(mag);
        end
    endfunction

    // Works out the world point for one sample under the current registers.
    // Returns 0 when the conditioned depth falls outside the window.
    function automatic bit project_sample(input logic [15:0] raw,
                                          input logic [CB-1:0] u, input logic [CB-1:0] v,
                                          output t_point pt);
        logic [15:0] depth;
        longint      xc;
        longint      yc;
        longint      zc;
        depth = swap_shadow ? {raw[7:0], raw[15:8]} : raw;
        // The no-return code is checked after the swap and counts as zero depth.
        if (depth == NO_RETURN) depth = '0;
        if (depth < window_shadow[15:0] || depth > window_shadow[31:16]) return 1'b0;
        xc = camera_offset_q12(u, centre_shadow[15:0], inv_focal_shadow[31:0], depth);
        yc = camera_offset_q12(v, centre_shadow[31:16], inv_focal_shadow[63:32], depth);
        zc = longint'(depth) <<< FRAC_CAM;
        pt.world_x = world_axis_mm(pose_shadow[0], xc, yc, zc);
        pt.world_y = world_axis_mm(pose_shadow[1], xc, yc, zc);
        pt.world_z = world_axis_mm(pose_shadow[2], xc, yc, zc);
        pt.column  = u;
        pt.row     = v;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker and transaction predictor. Both run on the rising edge and
    // see the values from before it; the check comes first so that a point
    // predicted at this edge can never be matched against a result at this edge.
    always @(posedge i_clk) begin
        t_point seen;
        t_point want;
        t_point predicted;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            seen = {o_world_x, o_world_y, o_world_z, o_point_column, o_point_row};
            if (pending_points.size() == 0) begin
                error_count++;
                $display("%0t: unexpected point, expected none, actual %h", $time, seen);
            end else begin
                want = pending_points[0];
                pending_points.delete(0);
                if ($isunknown(seen)) begin
                    error_count++;
                    $display("%0t: unknown bits in point, expected %h, actual %h",
                             $time, want, seen);
                end else begin
                    check_field("world_x", int'($signed(want.world_x)),
                                int'($signed(seen.world_x)));
                    check_field("world_y", int'($signed(want.world_y)),
                                int'($signed(seen.world_y)));
                    check_field("world_z", int'($signed(want.world_z)),
                                int'($signed(seen.world_z)));
                    check_field("point_column", int'(want.column), int'(seen.column));
                    check_field("point_row", int'(want.row), int'(seen.row));
                end
            end
        end
        // A transaction is taken on this edge: start high and busy low.
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            if (project_sample(i_raw_depth, i_pixel_column, i_pixel_row, predicted))
                pending_points.insert(pending_points.size(), predicted);
        end
    end

    // Offers one sample and returns at the falling edge after it was taken.
    // start is left high so back-to-back transactions need no gap.
    task automatic send_sample(input logic [15:0] raw, input logic [CB-1:0] u,
                               input logic [CB-1:0] v);
        i_raw_depth    = raw;
        i_pixel_column = u;
        i_pixel_row    = v;
        start          = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic maybe_idle(input int pct);
        if ($urandom_range(99) < pct) hold_off($urandom_range(17, 1));
    endtask

    // Stops sending, waits for every owed point, then lets the pipeline empty.
    // Points that never show up are failures and are dropped so the run goes on.
    task automatic drain_points();
        int waited;
        waited = 0;
        start  = 1'b0;
        while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_points.size() != 0) begin
            error_count += pending_points.size();
            $display("%0t: %0d expected points never arrived, first expected %h",
                     $time, pending_points.size(), pending_points[0]);
            pending_points.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write; only called while no transaction is in flight.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            CFG_DEPTH_WINDOW:    window_shadow    = data[31:0];
            CFG_SWAP_BYTES:      swap_shadow      = data[0];
            CFG_PRINCIPAL_POINT: centre_shadow    = data[31:0];
            CFG_INVERSE_FOCAL:   inv_focal_shadow = data;
            CFG_POSE_ROW_X:      pose_shadow[0]   = data;
            CFG_POSE_ROW_Y:      pose_shadow[1]   = data;
            CFG_POSE_ROW_Z:      pose_shadow[2]   = data;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly a plausible focal length between 200 and 2000 pixels, sometimes
    // any 32-bit value, now and then zero.
    function automatic logic [31:0] random_inverse_focal();
        case ($urandom_range(7))
            0:       return '0;
            1, 2:    return $urandom;
            default: return 32'((64'd1 << 32) / $urandom_range(2000, 200));
        endcase
    endfunction

    // Mostly rotation entries within +-1.0 and a translation that is either modest or
    // random; a quarter of the rows are fully random, which drives the saturation paths.
    function automatic logic [63:0] random_pose_row();
        logic [15:0] entry [3];
        logic [15:0] shift_mm;
        if ($urandom_range(3) == 0) return rand64();
        for (int k = 0; k < 3; k++)
            entry[k] = 16'(int'($urandom_range(32768)) - 16384);
        shift_mm = $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(4000)) - 2000);
        return {shift_mm, entry[2], entry[1], entry[0]};
    endfunction

    // Writes every register with a fresh random setting. Bits above a
    // register's width are filled at random since the block must ignore them.
    task automatic random_config();
        logic [15:0] lo;
        logic [15:0] hi;
        case ($urandom_range(7))
            0: begin
                lo = '0;
                hi = '1;
            end
            1: begin
                lo = 16'($urandom);
                hi = lo;
            end
            2: begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
            default: begin
                lo = 16'($urandom_range(2000));
                hi = lo + 16'($urandom_range(20000, 500));
            end
        endcase
        write_register(CFG_DEPTH_WINDOW, {$urandom, hi, lo});
        write_register(CFG_SWAP_BYTES, rand64());
        write_register(CFG_PRINCIPAL_POINT, rand64());
        write_register(CFG_INVERSE_FOCAL, {random_inverse_focal(), random_inverse_focal()});
        write_register(CFG_POSE_ROW_X, random_pose_row());
        write_register(CFG_POSE_ROW_Y, random_pose_row());
        write_register(CFG_POSE_ROW_Z, random_pose_row());
    endtask

    // Depth is mostly drawn inside the window so that most samples produce a
    // point; the rest are edges, just-outside values, no-return and noise. The
    // byte order is undone here so the window holds after the block swaps.
    function automatic logic [15:0] pick_raw_depth();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] depth;
        lo = window_shadow[15:0];
        hi = window_shadow[31:16];
        case ($urandom_range(19))
            0:       depth = NO_RETURN;
            1, 2:    depth = 16'($urandom);
            3:       depth = lo;
            4:       depth = hi;
            5:       depth = lo - 16'd1;
            6:       depth = hi + 16'd1;
            default: depth = (lo <= hi) ? 16'($urandom_range(hi, lo)) : 16'($urandom);
        endcase
        return swap_shadow ? {depth[7:0], depth[15:8]} : depth;
    endfunction

    function automatic logic [CB-1:0] pick_pixel();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic send_random_sample();
        send_sample(pick_raw_depth(), pick_pixel(), pick_pixel());
    endtask

    // Reset settings: window 150 to 3000 mm, zero inverse focal lengths and
    // the identity pose, so every accepted point is (0, 0, depth).
    task automatic test_reset_defaults();
        send_sample(16'd150, '0, '0);
        send_sample(16'd3000, '1, '1);
        send_sample(16'd149, 12'd7, 12'd9);
        send_sample(16'd3001, 12'd100, 12'd200);
        send_sample(16'd0, 12'd1, 12'd1);
        send_sample(NO_RETURN, 12'd2048, 12'd1024);
        send_sample(16'd1000, 12'd2048, 12'd100);
        drain_points();
    endtask

    task automatic test_special_cases();
        // Widest window and largest inverse focal lengths: zero depth and the
        // no-return code both land at the camera origin, large depth saturates.
        write_register(CFG_DEPTH_WINDOW, {32'd0, 16'hFFFF, 16'h0000});
        write_register(CFG_INVERSE_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(CFG_PRINCIPAL_POINT, {32'd0, 16'hFFFF, 16'h0000});
        send_sample(16'd0, 12'd12, 12'd34);
        send_sample(NO_RETURN, '1, '0);
        send_sample(16'd65534, '1, '1);
        send_sample(16'd65534, '0, '0);
        send_sample(16'd1, 12'd1, '1);
        drain_points();

        // Byte swap on; the no-return code reads the same in either byte order.
        write_register(CFG_SWAP_BYTES, 64'd1);
        send_sample(16'h3412, 12'd100, 12'd200);
        send_sample(NO_RETURN, 12'd300, 12'd400);
        send_sample(16'h0100, 12'd5, 12'd6);
        send_sample(16'hFFFE, '1, '0);
        drain_points();

        // Zero inverse focal on the y axis and the extreme pose entries.
        write_register(CFG_SWAP_BYTES, 64'd0);
        write_register(CFG_INVERSE_FOCAL, {32'h0000_0000, 32'h0001_0000});
        write_register(CFG_POSE_ROW_X, 64'h8000_8000_8000_8000);
        write_register(CFG_POSE_ROW_Y, 64'h7FFF_7FFF_7FFF_7FFF);
        write_register(CFG_POSE_ROW_Z, 64'h0001_7FFF_8000_0000);
        send_sample(16'd1000, '1, '0);
        send_sample(16'd65534, '0, '1);
        send_sample(16'd0, '0, '0);
        send_sample(16'd300, 12'd2048, 12'd2048);
        drain_points();

        // Minimum above maximum: nothing may come out.
        write_register(CFG_DEPTH_WINDOW, {32'd0, 16'd100, 16'd200});
        send_sample(16'd150, 12'd10, 12'd10);
        send_sample(16'd100, 12'd11, 12'd11);
        send_sample(16'd200, 12'd12, 12'd12);
        drain_points();

        // A window one millimetre wide.
        write_register(CFG_DEPTH_WINDOW, {32'd0, 16'd500, 16'd500});
        send_sample(16'd499, 12'd20, 12'd30);
        send_sample(16'd500, 12'd21, 12'd31);
        send_sample(16'd501, 12'd22, 12'd32);
        drain_points();
    endtask

    // A write to the unused index must leave every register as it was.
    task automatic test_unknown_index();
        random_config();
        write_register(CFG_UNUSED_INDEX, rand64());
        for (int k = 0; k < 20; k++) begin
            send_random_sample();
            maybe_idle(15);
        end
        drain_points();
    endtask

    // Random settings, each followed by a burst of random samples. The idle
    // rate changes every few dozen transactions so that some stretches run
    // at full rate and others have gaps at every pipeline phase.
    task automatic test_random_phases(input int phases, input int per_phase);
        int idle_pct;
        for (int p = 0; p < phases; p++) begin
            random_config();
            idle_pct = 0;
            for (int k = 0; k < per_phase; k++) begin
                if (k % 32 == 0) begin
                    case ($urandom_range(2))
                        0: idle_pct = 0;
                        1: idle_pct = 10;
                        default: idle_pct = 35;
                    endcase
                end
                send_random_sample();
                maybe_idle(idle_pct);
            end
            drain_points();
        end
    endtask

    // The sender stops mid-stream until every owed point has arrived, then
    // carries on under the same settings.
    task automatic test_pause_for_results();
        random_config();
        for (int k = 0; k < 20; k++) send_random_sample();
        drain_points();
        for (int k = 0; k < 20; k++) send_random_sample();
        drain_points();
    endtask

    // Last part of the run: one transaction per clock, no idling at all.
    task automatic test_back_to_back();
        random_config();
        for (int k = 0; k < 250; k++) send_random_sample();
    endtask

    initial begin
        error_count      = 0;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_raw_depth      = '0;
        i_pixel_column   = '0;
        i_pixel_row      = '0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        window_shadow    = RST_DEPTH_WINDOW;
        swap_shadow      = 1'b0;
        centre_shadow    = RST_PRINCIPAL_POINT;
        inv_focal_shadow = RST_INVERSE_FOCAL;
        pose_shadow[0]   = RST_POSE_ROW_X;
        pose_shadow[1]   = RST_POSE_ROW_Y;
        pose_shadow[2]   = RST_POSE_ROW_Z;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_unknown_index();
        test_random_phases(8, 165);
        test_pause_for_results();
        test_back_to_back();
        drain_points();

        if (error_count == 0) begin
            $display("** depth_pixel_to_world_point: PASSED **");
        end else begin
            $display("** depth_pixel_to_world_point: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("** depth_pixel_to_world_point: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/dpwp_pkg.sv
rtl/dpwp_back_project.sv
rtl/dpwp_world_axis.sv
rtl/depth_pixel_to_world_point.sv
rtl/dpwp_checker.sv
tb/tb_depth_pixel_to_world_point.sv
